[hw/rtl/boundary_tag_first_fit_allocator_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the boundary tag allocator
// Each macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the boundary tag allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam logic [15:0] HDR_BYTES   = 16'd24;
  localparam logic [15:0] TAKEN_BYTES = 16'd8;
  localparam logic [15:0] ALIGN_BYTES = 16'd8;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // request kinds
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // datapath micro-operations
  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_ZERO_RES, OP_FAIL_RES, OP_GRANT_RES, OP_REL_RES,
    OP_FMT0, OP_FMT1, OP_FMT2, OP_FMT3,
    OP_WALK_INIT, OP_WALK_RD, OP_WALK_CHK, OP_WALK_NEXT,
    OP_CUT0, OP_CUT1, OP_CUT2, OP_TAKE0, OP_TAKE1,
    OP_UL_RDN, OP_UL_RDP, OP_UL_CAP, OP_UL_WRN, OP_UL_WRP,
    OP_REL_RD, OP_REL_MARK, OP_REL_AFT,
    OP_CO_RDB, OP_CO_BSZ, OP_CO_BAFT, OP_CO_RDA, OP_CO_ACHK, OP_CO_ASZ, OP_CO_AAFT,
    OP_PU_N, OP_PU_P, OP_PU_H
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_rel;
    logic rel_ok;
    logic req_zero;
    logic ready;
    logic walk_valid;
    logic steps_done;
    logic fit;
    logic split;
    logic bfree;
    logic aft_free;
  } dp_stat_t;

endpackage

[hw/rtl/bta_datapath.sv]
// ----------------------------------------------------------------------------
// bta_datapath
// Arena memory, list head, working registers and result registers; runs
// one micro-operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module bta_datapath #(
  parameter int ARENA_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  bta_pkg::dp_cmd_t  cmd,
  input  logic              in_type,
  input  logic [15:0]       in_bytes,
  input  logic [15:0]       in_offset,
  output bta_pkg::dp_stat_t stat,
  output logic [1:0]        res_status,
  output logic [15:0]       res_offset
);
  import bta_pkg::*;

  localparam int DEPTH = ARENA_BYTES / 8;
  localparam int IW    = $clog2(DEPTH);
  localparam int SW    = IW + 1;
  localparam logic [15:0]   FMT_SIZE  = 16'(ARENA_BYTES - 48);
  localparam logic [15:0]   END_OFF   = 16'(ARENA_BYTES - 24);
  localparam logic [SW-1:0] STEP_LIM  = SW'(DEPTH);

  // arena store
  logic [63:0]   mem [DEPTH];
  logic [63:0]   rdata;
  logic          re, we;
  logic [15:0]   ra, wa;
  logic [3:0]    wl;
  logic [63:0]   wd;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (we && wl[i]) begin
        mem[wa[IW+2:3]][16*i +: 16] <= wd[16*i +: 16];
      end
    end
    if (re) begin
      rdata <= mem[ra[IW+2:3]];
    end
  end

  // working registers
  logic          is_rel, req_zero, ready, empty, walk_valid;
  logic [16:0]   size;
  logic [15:0]   rel, head, cur, ub, un, up, b, bef, aft, got, rest, bsz, asz, tb_bfree;
  logic          unv, upv;
  logic [63:0]   tcur;
  logic [SW-1:0] steps;

  logic [15:0] cs, rest_c, sz16, nb_bef, nb_aft;
  logic [17:0] need_fit, need_split;
  assign cs         = rdata[63:48];
  assign sz16       = size[15:0];
  assign rest_c     = tcur[63:48] - sz16 - HDR_BYTES;
  assign need_fit   = {1'b0, size} + 18'(TAKEN_BYTES);
  assign need_split = {1'b0, size} + 18'(ALIGN_BYTES) + 18'(HDR_BYTES);
  assign nb_bef     = cs + bsz + HDR_BYTES;
  assign nb_aft     = bsz + asz + HDR_BYTES;

  // status back to the controller
  always_comb begin
    stat.is_rel     = is_rel;
    stat.rel_ok     = (rel != 16'd0) && (rel[2:0] == 3'd0) && (rel >= HDR_BYTES) && ready;
    stat.req_zero   = req_zero;
    stat.ready      = ready;
    stat.walk_valid = walk_valid;
    stat.steps_done = (steps == STEP_LIM);
    stat.fit        = {2'b00, cs} >= need_fit;
    stat.split      = {2'b00, cs} >= need_split;
    stat.bfree      = (tb_bfree != 16'd0);
    stat.aft_free   = (rdata[47:32] != 16'd0);
  end

  // memory port control
  always_comb begin
    re = 1'b0; ra = '0; we = 1'b0; wa = '0; wl = 4'b0000; wd = '0;
    case (cmd.op)
      OP_FMT0:    begin we = 1'b1; wa = 16'd0; wl = 4'b1111;
                        wd = {FMT_SIZE, 16'd1, 16'd0, 16'd0}; end
      OP_FMT1:    begin we = 1'b1; wa = 16'd8;  wl = 4'b1111; end
      OP_FMT2:    begin we = 1'b1; wa = 16'd16; wl = 4'b1111; end
      OP_FMT3:    begin we = 1'b1; wa = END_OFF; wl = 4'b1111;
                        wd = {16'd0, 16'd0, FMT_SIZE, 16'd1}; end
      OP_WALK_RD: begin re = 1'b1; ra = cur; end
      OP_WALK_CHK: begin re = 1'b1; ra = cur + 16'd8; end
      OP_CUT0:    begin we = 1'b1; wa = cur; wl = 4'b1000; wd = {rest_c, 48'd0}; end
      OP_CUT1:    begin we = 1'b1; wa = got; wl = 4'b1111;
                        wd = {sz16, 16'd0, rest, tcur[47:32]}; end
      OP_CUT2:    begin we = 1'b1; wa = got + HDR_BYTES + sz16; wl = 4'b0011;
                        wd = {32'd0, sz16, 16'd0}; end
      OP_TAKE0:   begin we = 1'b1; wa = cur; wl = 4'b0100; end
      OP_TAKE1:   begin we = 1'b1; wa = cur + HDR_BYTES + tcur[63:48]; wl = 4'b0001; end
      OP_UL_RDN:  begin re = 1'b1; ra = ub + 16'd8; end
      OP_UL_RDP:  begin re = 1'b1; ra = ub + 16'd16; end
      OP_UL_WRN:  begin we = unv; wa = un + 16'd16; wl = 4'b1111;
                        wd = {47'd0, upv, up}; end
      OP_UL_WRP:  begin we = upv; wa = up + 16'd8; wl = 4'b1111;
                        wd = {47'd0, unv, un}; end
      OP_REL_RD:  begin re = 1'b1; ra = rel - HDR_BYTES; end
      OP_REL_MARK: begin we = 1'b1; wa = b; wl = 4'b0100; wd = {16'd0, 16'd1, 32'd0}; end
      OP_REL_AFT: begin we = 1'b1; wa = aft; wl = 4'b0001; wd = 64'd1; end
      OP_CO_RDB:  begin re = 1'b1; ra = bef; end
      OP_CO_BSZ:  begin we = 1'b1; wa = bef; wl = 4'b1000; wd = {nb_bef, 48'd0}; end
      OP_CO_BAFT: begin we = 1'b1; wa = aft; wl = 4'b0010; wd = {32'd0, bsz, 16'd0}; end
      OP_CO_RDA:  begin re = 1'b1; ra = aft; end
      OP_CO_ASZ:  begin we = 1'b1; wa = b; wl = 4'b1000; wd = {nb_aft, 48'd0}; end
      OP_CO_AAFT: begin we = 1'b1; wa = aft + HDR_BYTES + asz; wl = 4'b0010;
                        wd = {32'd0, bsz, 16'd0}; end
      OP_PU_N:    begin we = 1'b1; wa = b + 16'd8; wl = 4'b1111;
                        wd = {47'd0, !empty, head}; end
      OP_PU_P:    begin we = 1'b1; wa = b + 16'd16; wl = 4'b1111; end
      OP_PU_H:    begin we = !empty; wa = head + 16'd16; wl = 4'b1111;
                        wd = {47'd0, 1'b1, b}; end
      default:    begin end
    endcase
  end

  // list control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 16'd0;
      empty <= 1'b1;
      ready <= 1'b0;
    end else begin
      case (cmd.op)
        OP_FMT3: begin head <= 16'd0; empty <= 1'b0; ready <= 1'b1; end
        OP_UL_WRP: begin
          if (!upv) begin
            head  <= unv ? un : 16'd0;
            empty <= !unv;
          end
        end
        OP_PU_H: begin head <= b; empty <= 1'b0; end
        default: begin end
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_rel   <= in_type;
        rel      <= in_offset;
        req_zero <= (in_bytes == 16'd0);
        size     <= ({1'b0, in_bytes} + 17'd7) & ~17'd7;
      end
      OP_ZERO_RES:  begin res_status <= STAT_ZERO; res_offset <= 16'd0; end
      OP_FAIL_RES:  begin res_status <= STAT_FULL; res_offset <= 16'd0; end
      OP_GRANT_RES: begin res_status <= STAT_OK;   res_offset <= got + HDR_BYTES; end
      OP_REL_RES:   begin res_status <= STAT_OK;   res_offset <= 16'd0; end
      OP_WALK_INIT: begin cur <= head; walk_valid <= !empty; steps <= '0; end
      OP_WALK_CHK:  begin tcur <= rdata; ub <= cur; end
      OP_WALK_NEXT: begin
        walk_valid <= rdata[16];
        cur        <= rdata[15:0];
        steps      <= steps + SW'(1);
      end
      OP_CUT0:  begin rest <= rest_c; got <= cur + HDR_BYTES + rest_c; end
      OP_TAKE0: got <= cur;
      OP_UL_RDP: begin un <= rdata[15:0]; unv <= rdata[16]; end
      OP_UL_CAP: begin up <= rdata[15:0]; upv <= rdata[16]; end
      OP_REL_RD: b <= rel - HDR_BYTES;
      OP_REL_MARK: begin
        tb_bfree <= rdata[15:0];
        bsz      <= cs;
        aft      <= b + HDR_BYTES + cs;
        bef      <= b - HDR_BYTES - rdata[31:16];
        ub       <= b - HDR_BYTES - rdata[31:16];
      end
      OP_CO_BSZ:  begin bsz <= nb_bef; b <= bef; end
      OP_CO_ACHK: begin asz <= cs; ub <= aft; end
      OP_CO_ASZ:  bsz <= nb_aft;
      default: begin end
    endcase
  end

endmodule

[hw/rtl/bta_controller.sv]
// ----------------------------------------------------------------------------
// bta_controller
// Sequencer for allocate and release requests; issues datapath
// micro-operations and owns the output valid flag.
// ----------------------------------------------------------------------------
`include "boundary_tag_first_fit_allocator_unit_defines.svh"

module bta_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bta_pkg::dp_stat_t stat,
  output bta_pkg::dp_cmd_t  cmd
);
  import bta_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_ZERO, S_FAIL, S_GRANT, S_RRES,
    S_F0, S_F1, S_F2, S_F3,
    S_WINIT, S_WRD, S_WCHK, S_WNXT,
    S_CUT0, S_CUT1, S_CUT2, S_TK0, S_TK1,
    S_U0, S_U1, S_U2, S_U3, S_U4,
    S_RRD, S_RMK, S_RAF,
    S_CRB, S_CBS, S_CBA, S_CRA, S_CAC, S_CAS, S_CAA,
    S_P0, S_P1, S_P2
  } state_t;

  state_t state, ret;
  logic   out_free, accept;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // micro-operation for the current state
  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      S_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
      S_ZERO:  cmd.op = out_free ? OP_ZERO_RES : OP_NONE;
      S_FAIL:  cmd.op = out_free ? OP_FAIL_RES : OP_NONE;
      S_GRANT: cmd.op = out_free ? OP_GRANT_RES : OP_NONE;
      S_RRES:  cmd.op = out_free ? OP_REL_RES : OP_NONE;
      S_F0:    cmd.op = OP_FMT0;
      S_F1:    cmd.op = OP_FMT1;
      S_F2:    cmd.op = OP_FMT2;
      S_F3:    cmd.op = OP_FMT3;
      S_WINIT: cmd.op = OP_WALK_INIT;
      S_WRD:   cmd.op = OP_WALK_RD;
      S_WCHK:  cmd.op = OP_WALK_CHK;
      S_WNXT:  cmd.op = OP_WALK_NEXT;
      S_CUT0:  cmd.op = OP_CUT0;
      S_CUT1:  cmd.op = OP_CUT1;
      S_CUT2:  cmd.op = OP_CUT2;
      S_TK0:   cmd.op = OP_TAKE0;
      S_TK1:   cmd.op = OP_TAKE1;
      S_U0:    cmd.op = OP_UL_RDN;
      S_U1:    cmd.op = OP_UL_RDP;
      S_U2:    cmd.op = OP_UL_CAP;
      S_U3:    cmd.op = OP_UL_WRN;
      S_U4:    cmd.op = OP_UL_WRP;
      S_RRD:   cmd.op = OP_REL_RD;
      S_RMK:   cmd.op = OP_REL_MARK;
      S_RAF:   cmd.op = OP_REL_AFT;
      S_CRB:   cmd.op = OP_CO_RDB;
      S_CBS:   cmd.op = OP_CO_BSZ;
      S_CBA:   cmd.op = OP_CO_BAFT;
      S_CRA:   cmd.op = OP_CO_RDA;
      S_CAC:   cmd.op = OP_CO_ACHK;
      S_CAS:   cmd.op = OP_CO_ASZ;
      S_CAA:   cmd.op = OP_CO_AAFT;
      S_P0:    cmd.op = OP_PU_N;
      S_P1:    cmd.op = OP_PU_P;
      S_P2:    cmd.op = OP_PU_H;
      default: cmd.op = OP_NONE;
    endcase
  end

  // state, unlink return point and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result states set the flag themselves
      if (out_ready && !(state inside {S_ZERO, S_FAIL, S_GRANT, S_RRES})) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (accept) state <= S_DISP;
        S_DISP: begin
          if (stat.is_rel)        state <= stat.rel_ok ? S_RRD : S_RRES;
          else if (stat.req_zero) state <= S_ZERO;
          else if (!stat.ready)   state <= S_F0;
          else                    state <= S_WINIT;
        end
        S_ZERO, S_FAIL, S_GRANT, S_RRES: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_F0: state <= S_F1;
        S_F1: state <= S_F2;
        S_F2: state <= S_F3;
        S_F3: state <= S_WINIT;
        S_WINIT: state <= S_WRD;
        S_WRD: state <= (!stat.walk_valid || stat.steps_done) ? S_FAIL : S_WCHK;
        S_WCHK: begin
          if (!stat.fit)      state <= S_WNXT;
          else if (stat.split) state <= S_CUT0;
          else begin
            ret   <= S_TK0;
            state <= S_U0;
          end
        end
        S_WNXT: state <= S_WRD;
        S_CUT0: state <= S_CUT1;
        S_CUT1: state <= S_CUT2;
        S_CUT2: state <= S_GRANT;
        S_TK0:  state <= S_TK1;
        S_TK1:  state <= S_GRANT;
        S_U0: state <= S_U1;
        S_U1: state <= S_U2;
        S_U2: state <= S_U3;
        S_U3: state <= S_U4;
        S_U4: state <= ret;
        S_RRD: state <= S_RMK;
        S_RMK: state <= S_RAF;
        S_RAF: begin
          if (stat.bfree) begin
            ret   <= S_CRB;
            state <= S_U0;
          end else begin
            state <= S_CRA;
          end
        end
        S_CRB: state <= S_CBS;
        S_CBS: state <= S_CBA;
        S_CBA: state <= S_CRA;
        S_CRA: state <= S_CAC;
        S_CAC: begin
          if (stat.aft_free) begin
            ret   <= S_CAS;
            state <= S_U0;
          end else begin
            state <= S_P0;
          end
        end
        S_CAS: state <= S_CAA;
        S_CAA: state <= S_P0;
        S_P0: state <= S_P1;
        S_P1: state <= S_P2;
        S_P2: state <= S_RRES;
        default: state <= S_IDLE;
      endcase
    end
  end

  // a pending result is never overwritten
  `BTA_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready,
    cmd.op != OP_ZERO_RES && cmd.op != OP_FAIL_RES && cmd.op != OP_GRANT_RES &&
    cmd.op != OP_REL_RES, "result loaded while output stalled")
  // one request at a time
  `BTA_ASSERT_NEXT(a_one_req, accept, !in_ready, "request accepted while busy")
  // a result appears only from a result state
  `BTA_ASSERT_NOW(a_valid_src, $rose(out_valid),
    $past(state) == S_ZERO || $past(state) == S_FAIL || $past(state) == S_GRANT ||
    $past(state) == S_RRES, "output valid raised outside a result state")
  // unlink always returns to a known caller
  `BTA_ASSERT_NOW(a_ret_ok, state == S_U4,
    ret == S_TK0 || ret == S_CRB || ret == S_CAS, "bad unlink return point")

endmodule

[hw/rtl/boundary_tag_first_fit_allocator_unit.sv]
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_unit
// First-fit boundary tag allocator over an on-chip byte arena.
// ----------------------------------------------------------------------------
// One request is handled at a time. A zero-byte allocate or an ignored
// release answers without touching the arena; the first allocate also
// formats the arena. An allocate walks the free list first fit, then splits
// the block found or unlinks it whole; a failed walk answers FULL once the
// walk ends with no fit. A release marks the block free, merges it with a
// free block before and/or after it, and pushes it on the free list. The
// datapath reaches the arena one tag or link word per cycle, with a
// registered read. The arena needs no clearing after reset. The finished
// result sits in an output register; the next request is taken as soon as
// the result is loaded.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_unit #(
  parameter int ARENA_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] req_bytes, [31:16] release_offset
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] payload_offset
  output logic [1:0]  m_tuser    // [1:0] status
);
  import bta_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bta_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bta_datapath #(.ARENA_BYTES(ARENA_BYTES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_type    (s_tuser),
    .in_bytes   (s_tdata[15:0]),
    .in_offset  (s_tdata[31:16]),
    .stat       (stat),
    .res_status (m_tuser),
    .res_offset (m_tdata)
  );

endmodule

[test/boundary_tag_first_fit_allocator_unit_chk.sv]
// ----------------------------------------------------------------------------
// Allocator result checker
// Watches both stream channels of the allocator. It keeps its own copy of the
// arena tags and free list and predicts the status and payload offset of
// every accepted request. Each result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_unit_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  localparam int unsigned ARENA = 65536;
  localparam int unsigned HDR   = 24;
  localparam int unsigned TAKEN = 8;
  localparam int unsigned ALIGN = 8;
  localparam int F_BFREE = 0;
  localparam int F_BSIZE = 1;
  localparam int F_FREE  = 2;
  localparam int F_SIZE  = 3;
  localparam int L_NEXT  = 1;
  localparam int L_PREV  = 2;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] offset;
  } grant_t;

  logic [63:0] arena [0:8191];
  logic [15:0] free_head;
  bit          free_empty;
  bit          formatted;
  grant_t      grants_due [$];

  function automatic int unsigned tag_rd(int unsigned h, int f);
    return arena[(h >> 3) & 8191][16*f +: 16];
  endfunction

  function automatic void tag_wr(int unsigned h, int f, int unsigned v);
    arena[(h >> 3) & 8191][16*f +: 16] = v[15:0];
  endfunction

  function automatic bit link_rd(int unsigned h, int which, output int unsigned to);
    logic [63:0] w;
    w = arena[((h + 8*which) >> 3) & 8191];
    to = w[15:0];
    return w[16];
  endfunction

  function automatic void link_wr(int unsigned h, int which, bit vld, int unsigned to);
    arena[((h + 8*which) >> 3) & 8191] = {47'd0, vld, to[15:0]};
  endfunction

  function automatic int unsigned blk_after(int unsigned h);
    return (h + HDR + tag_rd(h, F_SIZE)) & 16'hFFFF;
  endfunction

  function automatic int unsigned blk_before(int unsigned h);
    return (h - HDR - tag_rd(h, F_BSIZE)) & 16'hFFFF;
  endfunction

  function automatic void list_unlink(int unsigned b);
    int unsigned n, p;
    bit nv, pv;
    nv = link_rd(b, L_NEXT, n);
    pv = link_rd(b, L_PREV, p);
    if (nv) link_wr(n, L_PREV, pv, p);
    if (pv) begin
      link_wr(p, L_NEXT, nv, n);
    end else begin
      free_head  = nv ? n[15:0] : 16'd0;
      free_empty = !nv;
    end
  endfunction

  function automatic void list_push(int unsigned b);
    link_wr(b, L_NEXT, !free_empty, free_head);
    link_wr(b, L_PREV, 1'b0, 0);
    if (!free_empty) link_wr(free_head, L_PREV, 1'b1, b);
    free_head  = b[15:0];
    free_empty = 1'b0;
  endfunction

  // split the tail of block b off as a new block of the given size
  function automatic int unsigned split_tail(int unsigned b, int unsigned size);
    int unsigned rest, fr, s;
    rest = tag_rd(b, F_SIZE) - (size + HDR);
    fr   = tag_rd(b, F_FREE);
    tag_wr(b, F_SIZE, rest);
    s = blk_after(b);
    tag_wr(s, F_BSIZE, rest);
    tag_wr(s, F_BFREE, fr);
    tag_wr(s, F_SIZE, size);
    tag_wr(s, F_FREE, fr);
    tag_wr(blk_after(s), F_BSIZE, size);
    return s;
  endfunction

  function automatic void arena_format();
    int unsigned size, last;
    size = ARENA - 2*HDR;
    last = ARENA - HDR;
    tag_wr(0, F_BFREE, 0);
    tag_wr(0, F_BSIZE, 0);
    tag_wr(0, F_FREE, 1);
    tag_wr(0, F_SIZE, size);
    link_wr(0, L_NEXT, 1'b0, 0);
    link_wr(0, L_PREV, 1'b0, 0);
    tag_wr(last, F_BFREE, 1);
    tag_wr(last, F_BSIZE, size);
    tag_wr(last, F_FREE, 0);
    tag_wr(last, F_SIZE, 0);
    free_head  = 16'd0;
    free_empty = 1'b0;
    formatted  = 1'b1;
  endfunction

  // merge a freed block with free neighbors and push it on the list
  function automatic void merge_free(int unsigned b);
    int unsigned aft, bef;
    aft = blk_after(b);
    bef = blk_before(b);
    if (tag_rd(b, F_BFREE) != 0) begin
      list_unlink(bef);
      tag_wr(bef, F_SIZE, tag_rd(bef, F_SIZE) + tag_rd(b, F_SIZE) + HDR);
      tag_wr(aft, F_BSIZE, tag_rd(bef, F_SIZE));
      b = bef;
    end
    if (tag_rd(aft, F_FREE) != 0) begin
      list_unlink(aft);
      tag_wr(b, F_SIZE, tag_rd(b, F_SIZE) + tag_rd(aft, F_SIZE) + HDR);
      tag_wr(blk_after(aft), F_BSIZE, tag_rd(b, F_SIZE));
    end
    list_push(b);
  endfunction

  function automatic grant_t predict_grant(logic kind, logic [15:0] bytes,
                                           logic [15:0] roff);
    grant_t g;
    int unsigned size, cur, steps, cs, got, nxt, b;
    bit vld;
    g.status = STAT_OK;
    g.offset = 16'd0;
    if (kind == REQ_RELEASE) begin
      if (roff != 0 && roff[2:0] == 3'd0 && roff >= HDR && formatted) begin
        b = roff - HDR;
        tag_wr(b, F_FREE, 1);
        tag_wr(blk_after(b), F_BFREE, 1);
        merge_free(b);
      end
      return g;
    end
    if (bytes == 0) begin
      g.status = STAT_ZERO;
      return g;
    end
    size = (bytes + ALIGN - 1) & ~(ALIGN - 1);
    if (!formatted) arena_format();
    cur   = free_head;
    vld   = !free_empty;
    steps = 0;
    while (vld && steps < ARENA / 8) begin
      cs = tag_rd(cur, F_SIZE);
      if (cs >= size + TAKEN) begin
        if (cs >= ALIGN + HDR + size) begin
          got = split_tail(cur, size);
        end else begin
          list_unlink(cur);
          got = cur;
        end
        tag_wr(got, F_FREE, 0);
        tag_wr(blk_after(got), F_BFREE, 0);
        g.offset = (got + HDR) & 16'hFFFF;
        return g;
      end
      vld = link_rd(cur, L_NEXT, nxt);
      cur = nxt;
      steps++;
    end
    g.status = STAT_FULL;
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // predict on every accepted request, compare on every accepted result
  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      for (int i = 0; i < 8192; i++) arena[i] = 64'd0;
      free_head  = 16'd0;
      free_empty = 1'b1;
      formatted  = 1'b0;
      grants_due.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (grants_due.size() == 0) begin
          report_mismatch("unexpected result, status", m_tuser, 0);
        end else begin
          g = grants_due.pop_front();
          if (m_tuser !== g.status) report_mismatch("status", m_tuser, g.status);
          if (m_tdata !== g.offset) report_mismatch("payload_offset", m_tdata, g.offset);
        end
      end
      if (s_tvalid && s_tready)
        grants_due.push_back(predict_grant(s_tuser, s_tdata[15:0], s_tdata[31:16]));
      pending = grants_due.size();
    end
  end
endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Allocator testbench
// Sends allocate and release requests to the allocator: a directed opening
// of edge cases, then random traffic whose releases target live allocations, apart from some with invalid offsets.
// Both sides idle at random in two phases, then run without idling; the checker predicts results.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [15:0] req_bytes, [31:16] release_offset
  logic        s_tuser;   // [0] req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [15:0] payload_offset
  logic [1:0]  m_tuser;   // [1:0] status

  int          fail_count;
  int          pending;
  int          sent;
  int          rcvd;
  int          tx_idle;
  int          rx_idle;
  bit          rx_hold_req;
  logic [15:0] live [$];

  boundary_tag_first_fit_allocator_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  boundary_tag_first_fit_allocator_unit_chk u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random backpressure, or one long hold-off when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // collect granted offsets so that only live blocks get released
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      rcvd++;
      if (m_tuser == STAT_OK && m_tdata != 16'd0) live.push_back(m_tdata);
    end
  end

  task automatic send_req(input logic kind, input logic [15:0] bytes,
                          input logic [15:0] roff);
    if ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {roff, bytes};
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic release_live(input int idx);
    logic [15:0] off;
    off = live[idx];
    live.delete(idx);
    send_req(REQ_RELEASE, 16'($urandom), off);
  endtask

  // hold the sender until every request has been answered
  task automatic drain();
    s_tvalid <= 1'b0;
    while (rcvd != sent) @(negedge clk);
  endtask

  initial begin
    int r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 32'd0;
    s_tuser = REQ_ALLOC;
    sent = 0;
    rcvd = 0;
    tx_idle = 17;
    rx_idle = 48;
    rx_hold_req = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: release before format, zero request, edge sizes, ignored releases
    send_req(REQ_RELEASE, 16'hFFFF, 16'd24);
    send_req(REQ_ALLOC, 16'd0, 16'hFFFF);
    send_req(REQ_ALLOC, 16'd1, 16'd0);
    send_req(REQ_ALLOC, 16'd16, 16'd0);
    send_req(REQ_ALLOC, 16'd16, 16'd0);
    send_req(REQ_ALLOC, 16'd16, 16'd0);
    send_req(REQ_ALLOC, 16'hFFFF, 16'd0);
    send_req(REQ_ALLOC, 16'd65521, 16'd0);
    send_req(REQ_RELEASE, 16'd0, 16'd0);
    send_req(REQ_RELEASE, 16'd0, 16'hFFFF);
    send_req(REQ_RELEASE, 16'd0, 16'd16);
    drain();
    // block with taken neighbors, then a fit too small to split that unlinks it whole
    release_live(2);
    drain();
    send_req(REQ_ALLOC, 16'd8, 16'd0);
    drain();
    release_live(1);
    release_live(1);
    drain();
    while (live.size() > 0) release_live(0);
    drain();
    // whole arena in one block, then one byte too many
    send_req(REQ_ALLOC, 16'd65480, 16'd0);
    send_req(REQ_ALLOC, 16'd8, 16'd0);
    drain();
    while (live.size() > 0) release_live(0);
    send_req(REQ_ALLOC, 16'd65481, 16'd0);
    drain();

    // random traffic
    for (int i = 0; i < 1150; i++) begin
      if (i == 380) begin
        tx_idle = 48;
        rx_idle = 17;
      end
      if (i == 760) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (i == 100) rx_hold_req = 1'b1;
      if (i == 500 || i == 900) drain();
      r = $urandom_range(99);
      if (r < 2) begin
        send_req(REQ_ALLOC, 16'd0, 16'($urandom));
      end else if (r < 4) begin
        case ($urandom_range(2))
          0: send_req(REQ_RELEASE, 16'($urandom), 16'd0);
          1: send_req(REQ_RELEASE, 16'($urandom), 16'($urandom) | 16'd1);
          default: send_req(REQ_RELEASE, 16'($urandom), 16'($urandom_range(1, 2) * 8));
        endcase
      end else if (r < 8) begin
        send_req(REQ_ALLOC, 16'($urandom_range(16384, 65535)), 16'($urandom));
      end else if (live.size() > 0 && (live.size() > 40 || r < 50)) begin
        release_live($urandom_range(live.size() - 1));
      end else if (r < 90) begin
        send_req(REQ_ALLOC, 16'($urandom_range(1, 256)), 16'($urandom));
      end else begin
        send_req(REQ_ALLOC, 16'($urandom_range(1, 4096)), 16'($urandom));
      end
    end
    drain();
    repeat (100) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
